// ----- hw/rtl/i2crts_pkg.sv -----
// Package: shared types, codes and constants of the I2C register transfer sequencer.
package i2crts_pkg;

   localparam int BUF_DEPTH_DEFAULT = 16;
   localparam int LOAD_SLOTS        = 16;   // slots that the 4-bit load index can reach
   localparam int LEN_LIMIT         = 31;   // largest value of the 5-bit length field

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2,
      REQ_STEP  = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_STOP    = 3'd2,
      CMD_RESTART = 3'd3,
      CMD_RECEIVE = 3'd4,
      CMD_ACK     = 3'd5,
      CMD_NACK    = 3'd6
   } bus_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE      = 4'd0,
      S_W_INIT    = 4'd1,
      S_W_START   = 4'd2,
      S_W_ADDR    = 4'd3,
      S_W_DATA    = 4'd4,
      S_W_STOP    = 4'd5,
      S_R_INIT    = 4'd6,
      S_R_START   = 4'd7,
      S_R_ADDR    = 4'd8,
      S_R_SUB     = 4'd9,
      S_R_RESTART = 4'd10,
      S_R_RADDR   = 4'd11,
      S_R_RECV    = 4'd12,
      S_R_ACK     = 4'd13,
      S_R_STOP    = 4'd14
   } seq_state_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [6:0] sub_address;
      logic [4:0] xfer_length;
      logic [3:0] load_index;
      logic [7:0] load_byte;
      logic       ack_status;
      logic [7:0] rx_data;
   } req_item_type;

   typedef struct packed {
      logic [2:0] bus_command;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [3:0] rx_index;
      logic [7:0] rx_byte;
      logic       busy_res;
      logic       error;
   } rsp_item_type;

endpackage

// ----- hw/rtl/i2crts_req_if.sv -----
// Interface: request channel carrying one event item.
interface i2crts_req_if
   import i2crts_pkg::*;
();
   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/i2crts_rsp_if.sv -----
// Interface: response channel carrying one result item.
interface i2crts_rsp_if
   import i2crts_pkg::*;
();
   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/i2crts_csr_if.sv -----
// Interface: configuration write channel for the slave address register.
interface i2crts_csr_if ();
   logic       valid;
   logic       ready;
   logic [6:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/i2c_master_register_transfer_sequencer.sv -----
// Top level: I2C master register write/read sequencer, one bus event per item.
//
// Usage:
//   req_chan carries one event item: load a transmit byte, start a register
//   write, start a register read, or report that the last bus step completed
//   (with the slave acknowledge and any received byte).
//   rsp_chan returns exactly one result item per request: the bus command to
//   issue, a byte to transmit, a received byte with its position, and the
//   busy and sticky error flags as they stand after the event.
//   csr_chan writes the 7-bit slave address; it is always ready and should be
//   written only while no transfer is in progress.
// Timing: the result is registered and shows on rsp_chan in the cycle after
//   the request is accepted; one item per cycle is sustained while rsp_chan.ready
//   is high, bounded only by the single state update per event.
// Stall: the result register holds while rsp_chan.ready is low; a new item is
//   accepted only when the result register is empty or being emptied.
// Reset: synchronous, active high; the sequencer goes idle with busy and
//   error clear and the slave address zero. The transmit buffer is not cleared.
module i2c_master_register_transfer_sequencer
   import i2crts_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   i2crts_req_if.sink  req_chan,
   i2crts_rsp_if.source rsp_chan,
   i2crts_csr_if.sink  csr_chan
);

   // Only slots below both the depth and the load index range are ever written.
   localparam int SLOTS   = (BUF_DEPTH < LOAD_SLOTS) ? BUF_DEPTH : LOAD_SLOTS;
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LEN_MAX = (BUF_DEPTH < LEN_LIMIT) ? BUF_DEPTH : LEN_LIMIT;

   seq_state_type state_ff,   state_in;
   logic [4:0]    byte_idx_ff, byte_idx_in;
   logic [4:0]    send_cnt_ff, send_cnt_in;
   logic [4:0]    recv_cnt_ff, recv_cnt_in;
   logic [6:0]    reg_addr_ff, reg_addr_in;
   logic          busy_ff,     busy_in;
   logic          error_ff,    error_in;
   logic [6:0]    slave_addr_ff;
   logic [7:0]    tx_buf_ff [2**IDX_W];

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_ff,       rsp_in;

   req_item_type  req;
   logic          req_acc;
   logic [4:0]    len_clamped;
   logic [4:0]    byte_idx_inc;
   logic          is_start;
   logic          step_fail;
   seq_state_type restart_state;
   logic [7:0]    buf_byte;

   assign req      = req_chan.data;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   // Saturate the requested length to the buffer depth or the 5-bit limit, whichever is less.
   assign len_clamped  = (req.xfer_length > 5'(LEN_MAX)) ? 5'(LEN_MAX) : req.xfer_length;
   assign byte_idx_inc = byte_idx_ff + 5'd1;
   assign buf_byte     = tx_buf_ff[byte_idx_ff[IDX_W-1:0]];
   assign is_start     = (req.req_type == REQ_WRITE) || (req.req_type == REQ_READ);

   // A slave NACK counts only in states that wait on an acknowledge.
   always_comb begin
      step_fail = 1'b0;
      case (state_ff)
         S_W_ADDR, S_W_DATA, S_W_STOP, S_R_ADDR, S_R_SUB, S_R_RADDR: begin
            step_fail = req.ack_status;
         end
         default: begin
            step_fail = 1'b0;
         end
      endcase
   end

   // Restart the sequence that failed from its START.
   always_comb begin
      case (state_ff)
         S_R_ADDR, S_R_SUB, S_R_RADDR: restart_state = S_R_INIT;
         default:                      restart_state = S_W_INIT;
      endcase
   end

   // Next state and sequencer registers.
   always_comb begin
      state_in    = state_ff;
      byte_idx_in = byte_idx_ff;
      send_cnt_in = send_cnt_ff;
      recv_cnt_in = recv_cnt_ff;
      reg_addr_in = reg_addr_ff;
      busy_in     = busy_ff;
      error_in    = error_ff;
      if (is_start && !busy_ff) begin
         reg_addr_in = req.sub_address;
         byte_idx_in = 5'd0;
         busy_in     = 1'b1;
         if (req.req_type == REQ_WRITE) begin
            send_cnt_in = len_clamped;
            state_in    = S_W_START;
         end else begin
            recv_cnt_in = len_clamped;
            state_in    = S_R_START;
         end
      end else if (req.req_type == REQ_STEP) begin
         if (step_fail) begin
            error_in    = 1'b1;
            byte_idx_in = 5'd0;
            state_in    = restart_state;
         end else begin
            case (state_ff)
               S_W_INIT: begin
                  byte_idx_in = 5'd0;
                  state_in    = S_W_START;
               end
               S_R_INIT: begin
                  byte_idx_in = 5'd0;
                  state_in    = S_R_START;
               end
               S_W_START:   state_in = S_W_ADDR;
               S_R_START:   state_in = S_R_ADDR;
               S_W_ADDR:    state_in = S_W_DATA;
               S_R_ADDR:    state_in = S_R_SUB;
               S_W_DATA: begin
                  if (byte_idx_ff < send_cnt_ff) begin
                     byte_idx_in = byte_idx_inc;
                  end else begin
                     byte_idx_in = 5'd0;
                     state_in    = S_W_STOP;
                  end
               end
               S_W_STOP: begin
                  byte_idx_in = 5'd0;
                  busy_in     = 1'b0;
                  state_in    = S_IDLE;
               end
               S_R_SUB:     state_in = S_R_RESTART;
               S_R_RESTART: state_in = S_R_RADDR;
               S_R_RADDR:   state_in = S_R_RECV;
               S_R_RECV: begin
                  byte_idx_in = byte_idx_inc;
                  state_in    = (byte_idx_inc < recv_cnt_ff) ? S_R_ACK : S_R_STOP;
               end
               S_R_ACK:     state_in = S_R_RECV;
               S_R_STOP: begin
                  byte_idx_in = 5'd0;
                  busy_in     = 1'b0;
                  state_in    = S_IDLE;
               end
               default: begin
                  state_in = state_ff;
               end
            endcase
         end
      end
   end

   // Result item for the event.
   always_comb begin
      rsp_in             = '0;
      rsp_in.bus_command = CMD_NONE;
      if (is_start && !busy_ff) begin
         rsp_in.bus_command = CMD_START;
      end else if (req.req_type == REQ_STEP) begin
         if (step_fail) begin
            rsp_in.bus_command = CMD_STOP;
         end else begin
            case (state_ff)
               S_W_INIT, S_R_INIT: rsp_in.bus_command = CMD_START;
               S_W_START, S_R_START: begin
                  rsp_in.tx_valid = 1'b1;
                  rsp_in.tx_byte  = {slave_addr_ff, 1'b0};
               end
               S_W_ADDR, S_R_ADDR: begin
                  rsp_in.tx_valid = 1'b1;
                  rsp_in.tx_byte  = {1'b1, reg_addr_ff};   // auto-increment bit
               end
               S_W_DATA: begin
                  if (byte_idx_ff < send_cnt_ff) begin
                     rsp_in.tx_valid = 1'b1;
                     rsp_in.tx_byte  = buf_byte;
                  end else begin
                     rsp_in.bus_command = CMD_STOP;
                  end
               end
               S_R_SUB:     rsp_in.bus_command = CMD_RESTART;
               S_R_RESTART: begin
                  rsp_in.tx_valid = 1'b1;
                  rsp_in.tx_byte  = {slave_addr_ff, 1'b1};
               end
               S_R_RADDR, S_R_ACK: rsp_in.bus_command = CMD_RECEIVE;
               S_R_RECV: begin
                  rsp_in.rx_valid    = 1'b1;
                  rsp_in.rx_index    = byte_idx_ff[3:0];
                  rsp_in.rx_byte     = req.rx_data;
                  rsp_in.bus_command = (byte_idx_inc < recv_cnt_ff) ? CMD_ACK : CMD_NACK;
               end
               S_R_STOP:    rsp_in.bus_command = CMD_STOP;
               default: begin
                  rsp_in.bus_command = CMD_NONE;
               end
            endcase
         end
      end
      rsp_in.busy_res = busy_in;
      rsp_in.error    = error_in;
   end

   // Hold the result until taken; refill on each accepted item.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_acc) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         byte_idx_ff   <= 5'd0;
         send_cnt_ff   <= 5'd0;
         recv_cnt_ff   <= 5'd0;
         reg_addr_ff   <= 7'd0;
         busy_ff       <= 1'b0;
         error_ff      <= 1'b0;
         slave_addr_ff <= 7'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_acc) begin
            state_ff    <= state_in;
            byte_idx_ff <= byte_idx_in;
            send_cnt_ff <= send_cnt_in;
            recv_cnt_ff <= recv_cnt_in;
            reg_addr_ff <= reg_addr_in;
            busy_ff     <= busy_in;
            error_ff    <= error_in;
         end
         if (csr_chan.valid) begin
            slave_addr_ff <= csr_chan.data;
         end
      end
   end

   // Result payload and transmit buffer need no reset.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_ff <= rsp_in;
      end
      if (req_acc && (req.req_type == REQ_LOAD) && (int'(req.load_index) < BUF_DEPTH)) begin
         tx_buf_ff[req.load_index[IDX_W-1:0]] <= req.load_byte;
      end
   end

`ifndef SYNTHESIS
   a_start_issues_start: assert property (@(posedge clock) disable iff (reset)
      req_acc && is_start && !busy_ff |=>
         rsp_valid_ff && (rsp_ff.bus_command == CMD_START) && rsp_ff.busy_res)
      else $error("accepted start did not issue START");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff |=> error_ff)
      else $error("error flag cleared without reset");

   a_idle_matches_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) == !busy_ff)
      else $error("idle state and busy flag disagree");

   a_tx_rx_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.tx_valid && rsp_ff.rx_valid))
      else $error("transmit and receive in the same item");
`endif

endmodule
